// ===== hw/rtl/nca_pkg.sv =====
// Package for the nearest-centre assignment block: item, result and token types.
// It also holds the field widths, the item kind codes and the register indexes.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package nca_pkg;

	localparam int COORD_BITS    = 16;
	localparam int NUM_FIELDS    = 4;
	localparam int SLOT_BITS     = 4;
	localparam int LABEL_BITS    = 4;
	localparam int DIST_BITS     = 34;
	localparam int SQ_BITS       = 2 * COORD_BITS + 1;
	localparam int COUNT_BITS    = 5;
	localparam int DIMS_BITS     = 3;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 5;

	localparam logic [COUNT_BITS-1:0] CENTER_COUNT_RST = COUNT_BITS'(1);
	localparam logic [DIMS_BITS-1:0]  DIMS_IN_USE_RST  = DIMS_BITS'(4);

	typedef enum logic [0:0] {
		KIND_LOAD     = 1'b0,
		KIND_CLASSIFY = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_CENTER_COUNT = 1'b0,
		CFG_DIMS_IN_USE  = 1'b1
	} cfg_reg_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [SQ_BITS-1:0]           sq_t;
	typedef logic [DIST_BITS-1:0]         dist_t;

	typedef struct packed {
		kind_t                  kind;
		logic [SLOT_BITS-1:0]   center_slot;
		coord_t                 coord_a;
		coord_t                 coord_b;
		coord_t                 coord_c;
		coord_t                 coord_d;
	} item_t;

	typedef struct packed {
		logic [LABEL_BITS-1:0]  label;
		dist_t                  best_distance;
	} result_t;

	// What travels from cell to cell: the item itself and the best match so far.
	typedef struct packed {
		kind_t                          kind;
		logic [SLOT_BITS-1:0]           slot;
		logic [NUM_FIELDS-1:0][COORD_BITS-1:0] coord;
		dist_t                          best_dist;
		logic [LABEL_BITS-1:0]          best_label;
	} tok_t;

	// Per-cell control derived from the configuration registers.
	typedef struct packed {
		logic                   active;
		logic [NUM_FIELDS-1:0]  dim_en;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nearest_center_assign.sv =====
// Nearest-centre assignment: labels each point item with its closest stored centre.
// Each item passes both register stages of every cell, then the output register.
// Throughput: one item per cycle while the result side does not stall; every cell
// of the chain has two register stages and all of them advance together.
// Reset clears the valid flags and sets center_count to 1 and dims_in_use to 4;
// centre entries are undefined until loaded and have no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module nearest_center_assign import nca_pkg::*; #(
	parameter int MAX_CENTERS = 16,
	parameter int DIMS        = 4
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata,
	input  wire logic                      point_valid,
	output logic                           point_stall,
	input  wire item_t                     point_item,
	output logic                           result_valid,
	input  wire logic                      result_stall,
	output result_t                        result_item
);

	// Only the first four coordinates exist on the input, so no more are ever compared.
	localparam int NCMP = (DIMS < NUM_FIELDS) ? DIMS : NUM_FIELDS;

	logic [COUNT_BITS-1:0] center_count_q;
	logic [DIMS_BITS-1:0]  dims_in_use_q;

	// Configuration registers. The user must see that they are only written while the block
	// is idle, so the cells may read them directly; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_count_q <= CENTER_COUNT_RST;
			dims_in_use_q  <= DIMS_IN_USE_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_CENTER_COUNT: center_count_q <= cfg_wdata[COUNT_BITS-1:0];
				CFG_DIMS_IN_USE:  dims_in_use_q  <= cfg_wdata[DIMS_BITS-1:0];
			endcase
		end
	end

	// The whole chain moves as one: it advances whenever the output register is
	// empty or its item is being taken. A held result therefore stalls the input.
	logic adv;
	assign adv         = !result_valid || !result_stall;
	assign point_stall = !adv;

	// Coordinate enables. The first coordinate is always compared, so a dimension
	// count of zero behaves as one; counts above the stored dimensions saturate
	// because those coordinates simply do not exist in the cells.
	logic [NUM_FIELDS-1:0] dim_en;
	always_comb begin
		for (int t = 0; t < NUM_FIELDS; t++) begin
			dim_en[t] = (t == 0) || (32'(dims_in_use_q) > 32'(t));
		end
	end

	// The chain: entry 0 is the accepted item, entry k+1 is the output of cell k.
	logic [MAX_CENTERS:0] valid_c;
	tok_t                 tok_c [MAX_CENTERS+1];
	tok_t                 head_tok;

	always_comb begin
		head_tok.kind       = point_item.kind;
		head_tok.slot       = point_item.center_slot;
		head_tok.coord[0]   = point_item.coord_a;
		head_tok.coord[1]   = point_item.coord_b;
		head_tok.coord[2]   = point_item.coord_c;
		head_tok.coord[3]   = point_item.coord_d;
		head_tok.best_dist  = '0;
		head_tok.best_label = '0;
	end

	assign valid_c[0] = point_valid && !point_stall;
	assign tok_c[0]   = head_tok;

	// Cell k holds centre k. Cell 0 always takes its own distance as the starting
	// best, which is also how a centre count of zero comes to compare entry 0 only.
	// A cell at or beyond the centre count passes the item on untouched, so counts
	// above MAX_CENTERS saturate without further logic.
	for (genvar k = 0; k < MAX_CENTERS; k++) begin : g_cell
		cell_ctl_t ctl;
		assign ctl.active = (32'(center_count_q) > 32'(k));
		assign ctl.dim_en = dim_en;

		nca_cell #(
			.CELL_IDX (k),
			.NCMP     (NCMP)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.adv           (adv),
			.ctl           (ctl),
			.tok_in_valid  (valid_c[k]),
			.tok_in        (tok_c[k]),
			.tok_out_valid (valid_c[k+1]),
			.tok_out       (tok_c[k+1])
		);
	end

	// Output register. A load item leaves the chain here and produces no result.
	logic    result_valid_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= valid_c[MAX_CENTERS] &&
				(tok_c[MAX_CENTERS].kind == KIND_CLASSIFY);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q.label         <= tok_c[MAX_CENTERS].best_label;
			result_q.best_distance <= tok_c[MAX_CENTERS].best_dist;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

	// While the output is held, no item may move anywhere in the chain.
	a_chain_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_c[MAX_CENTERS:1]))
		else $error("chain moved while the output was held");

	// A delivered label always names a centre in use (entry 0 when the count is zero).
	a_label_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_item.label == '0) ||
			(32'(result_item.label) < 32'(center_count_q)))
		else $error("label names a centre outside the count in use");

endmodule

`default_nettype wire

// ===== hw/rtl/nca_cell.sv =====
// One cell of the centre chain: holds one centre and compares passing points with it.
// Two register stages: squared differences, then sum and compare with the best so far.
// Depends on nca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nca_cell import nca_pkg::*; #(
	parameter int CELL_IDX = 0,
	parameter int NCMP     = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      adv,
	input  wire cell_ctl_t ctl,
	input  wire logic      tok_in_valid,
	input  wire tok_t      tok_in,
	output logic           tok_out_valid,
	output tok_t           tok_out
);

	localparam bit FIRST    = (CELL_IDX == 0);
	localparam bit LOADABLE = (CELL_IDX < (1 << SLOT_BITS));
	localparam logic [SLOT_BITS-1:0]  MY_SLOT  = SLOT_BITS'(CELL_IDX);
	localparam logic [LABEL_BITS-1:0] MY_LABEL = LABEL_BITS'(CELL_IDX);

	coord_t center_q [NCMP];

	logic signed [COORD_BITS:0]     diff [NCMP];
	logic signed [2*COORD_BITS+1:0] prod [NCMP];
	sq_t                            sq_d [NCMP];
	sq_t                            sq_s1 [NCMP];
	logic                           valid_s1;
	tok_t                           tok_s1;
	logic                           valid_s2;
	tok_t                           tok_s2;
	tok_t                           tok_nx;
	logic                           load_hit;
	dist_t                          sum;
	logic                           take;

	// A load item writes the centre as it enters this cell, so items ahead of it
	// in the chain still see the old centre and items behind it see the new one.
	assign load_hit = LOADABLE && tok_in_valid && (tok_in.kind == KIND_LOAD) &&
		(tok_in.slot == MY_SLOT);

	always_ff @(posedge clk) begin
		if (adv && load_hit) begin
			for (int t = 0; t < NCMP; t++) begin
				center_q[t] <= tok_in.coord[t];
			end
		end
	end

	always_comb begin
		for (int t = 0; t < NCMP; t++) begin
			diff[t] = $signed({tok_in.coord[t][COORD_BITS-1], tok_in.coord[t]}) -
				$signed({center_q[t][COORD_BITS-1], center_q[t]});
			prod[t] = diff[t] * diff[t];
			sq_d[t] = ctl.dim_en[t] ? prod[t][SQ_BITS-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= tok_in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s1 <= tok_in;
			for (int t = 0; t < NCMP; t++) begin
				sq_s1[t] <= sq_d[t];
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int t = 0; t < NCMP; t++) begin
			sum = sum + DIST_BITS'(sq_s1[t]);
		end
		// Strict less-than keeps the lower index on a tie.
		take = FIRST || (ctl.active && (sum < tok_s1.best_dist));
		tok_nx = tok_s1;
		if (take) begin
			tok_nx.best_dist  = sum;
			tok_nx.best_label = MY_LABEL;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s2 <= tok_nx;
		end
	end

	assign tok_out_valid = valid_s2;
	assign tok_out       = tok_s2;

endmodule

`default_nettype wire
